### src/pce_pkg.sv
// Package for the parameterized CRC engine: configuration register map,
// register field widths and the configuration struct. No dependencies.
`timescale 1ns / 1ps

package pce_pkg;

    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_W      = 3;
    localparam int CW_W       = 7;

    localparam logic [IDX_W-1:0] REG_CRC_WIDTH      = 3'd0;
    localparam logic [IDX_W-1:0] REG_POLYNOMIAL     = 3'd1;
    localparam logic [IDX_W-1:0] REG_INIT_VALUE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_REFLECT_INPUT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_REFLECT_OUTPUT = 3'd4;
    localparam logic [IDX_W-1:0] REG_FINAL_XOR      = 3'd5;

    localparam logic [CW_W-1:0]   RST_CRC_WIDTH  = 7'd32;
    localparam logic [DATA_W-1:0] RST_POLYNOMIAL = 64'h0000_0000_04C1_1DB7;
    localparam logic [DATA_W-1:0] RST_INIT_VALUE = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] RST_FINAL_XOR  = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [CW_W-1:0]   crc_width;
        logic [DATA_W-1:0] polynomial;
        logic [DATA_W-1:0] init_value;
        logic              reflect_input;
        logic              reflect_output;
        logic [DATA_W-1:0] final_xor;
    } pce_cfg_t;

endpackage

### src/pce_regs.sv
// APB-style configuration register file for the CRC engine.
// Depends on pce_pkg for the register map and the pce_cfg_t struct.
`timescale 1ns / 1ps

module pce_regs
    import pce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output pce_cfg_t          cfg
);

    pce_cfg_t         cfg_reg;
    logic [IDX_W-1:0] reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_width      <= RST_CRC_WIDTH;
            cfg_reg.polynomial     <= RST_POLYNOMIAL;
            cfg_reg.init_value     <= RST_INIT_VALUE;
            cfg_reg.reflect_input  <= 1'b1;
            cfg_reg.reflect_output <= 1'b1;
            cfg_reg.final_xor      <= RST_FINAL_XOR;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CRC_WIDTH:      cfg_reg.crc_width      <= pwdata[CW_W-1:0];
                REG_POLYNOMIAL:     cfg_reg.polynomial     <= pwdata;
                REG_INIT_VALUE:     cfg_reg.init_value     <= pwdata;
                REG_REFLECT_INPUT:  cfg_reg.reflect_input  <= pwdata[0];
                REG_REFLECT_OUTPUT: cfg_reg.reflect_output <= pwdata[0];
                REG_FINAL_XOR:      cfg_reg.final_xor      <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CRC_WIDTH:      prdata = DATA_W'(cfg_reg.crc_width);
            REG_POLYNOMIAL:     prdata = cfg_reg.polynomial;
            REG_INIT_VALUE:     prdata = cfg_reg.init_value;
            REG_REFLECT_INPUT:  prdata = DATA_W'(cfg_reg.reflect_input);
            REG_REFLECT_OUTPUT: prdata = DATA_W'(cfg_reg.reflect_output);
            REG_FINAL_XOR:      prdata = cfg_reg.final_xor;
            default:            prdata = '0;
        endcase
    end

endmodule

### src/pce_core.sv
// CRC datapath: input beat register, byte update of the running value,
// finalization and output register. Depends on pce_pkg.
`timescale 1ns / 1ps

module pce_core
    import pce_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pce_cfg_t          cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] crc_result
);

    localparam int WB = $clog2(MAX_WIDTH + 1);

    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic                 s1_bv_reg;
    logic                 s1_last_reg;
    logic                 in_msg_reg;
    logic [MAX_WIDTH-1:0] run_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    crc_result_reg;

    logic                 s1_adv;
    logic                 s1_act;
    logic [WB-1:0]        eff_w;
    logic [WB-1:0]        rshift;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] top_mask;
    logic [MAX_WIDTH-1:0] poly;
    logic [MAX_WIDTH-1:0] crc_next;
    logic [MAX_WIDTH-1:0] crc_rev;
    logic [MAX_WIDTH-1:0] crc_fin;
    logic [7:0]           byte_in;

    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign s1_act    = s1_bv_reg || s1_last_reg;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign out_valid = out_valid_reg;
    assign crc_result = crc_result_reg;

    always_comb
    begin
        if (cfg.crc_width < CW_W'(8))
            eff_w = WB'(8);
        else if (cfg.crc_width > CW_W'(MAX_WIDTH))
            eff_w = WB'(MAX_WIDTH);
        else
            eff_w = WB'(cfg.crc_width);
        rshift   = WB'(MAX_WIDTH) - eff_w;
        mask     = {MAX_WIDTH{1'b1}} >> rshift;
        top_mask = mask ^ (mask >> 1);
        poly     = cfg.polynomial[MAX_WIDTH-1:0] & mask;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            byte_in[i] = cfg.reflect_input ? s1_byte_reg[7-i] : s1_byte_reg[i];
        crc_next = (in_msg_reg ? run_reg : cfg.init_value[MAX_WIDTH-1:0]) & mask;
        if (s1_bv_reg)
        begin
            crc_next = crc_next ^ (MAX_WIDTH'(byte_in) << (eff_w - WB'(8)));
            for (int k = 0; k < 8; k++)
            begin
                if (|(crc_next & top_mask))
                    crc_next = ((crc_next << 1) ^ poly) & mask;
                else
                    crc_next = (crc_next << 1) & mask;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
            crc_rev[i] = crc_next[MAX_WIDTH-1-i];
        crc_fin = cfg.reflect_output ? (crc_rev >> rshift) : crc_next;
        crc_fin = (crc_fin ^ cfg.final_xor[MAX_WIDTH-1:0]) & mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv && s1_act)
                in_msg_reg <= !s1_last_reg;

            if (s1_adv && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= '0;
        else if (s1_adv && s1_act)
            run_reg <= crc_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_bv_reg   <= byte_valid;
            s1_last_reg <= last_byte;
        end
        if (s1_adv && s1_last_reg)
            crc_result_reg <= DATA_W'(crc_fin);
    end

endmodule

### src/parameterized_crc_engine.sv
// Top level of the parameterized CRC engine (Rocksoft model, 8 to 64 bits).
// Each accepted beat is registered in the input beat register, and a last
// beat's result in the output register. Throughput: one input beat per
// cycle while in_stall is low; eight unrolled polynomial steps per byte.
// Reset: registers return to CRC-32 defaults, running value and message
// state clear, no beats pending. Depends on pce_pkg, pce_regs, pce_core.
`timescale 1ns / 1ps

module parameterized_crc_engine
    import pce_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] crc_result
);

    pce_cfg_t cfg;

    pce_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pce_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .crc_result (crc_result)
    );

endmodule
